### src/iou_match_pkg.sv
// Package with shared constants, types and result codes of the IoU matcher.
package iou_match_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int COORD_BITS  = 12;

  localparam int IDX_BITS   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_BITS   = $clog2(TABLE_DEPTH + 1);
  localparam int AREA_BITS  = 2 * COORD_BITS;
  localparam int UNION_BITS = AREA_BITS + 1;
  localparam int PROD_BITS  = AREA_BITS + UNION_BITS;
  localparam int QUOT_BITS  = 17;
  localparam int THR_BITS   = 16;
  localparam int BOX_BITS   = 4 * COORD_BITS;

  localparam logic [1:0] FUNC_LOAD  = 2'd0;
  localparam logic [1:0] FUNC_EVAL  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NO_MATCH = 2'd1;
  localparam logic [1:0] STATUS_FULL     = 2'd2;

  localparam logic REG_KEEP_HIGH = 1'b0;
  localparam logic REG_KEEP_LOW  = 1'b1;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t l;
    coord_t t;
    coord_t r;
    coord_t b;
  } box_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PAREA,
    S_READ,
    S_DIM,
    S_MUL,
    S_UNI,
    S_CMP,
    S_UPD,
    S_DIV_START,
    S_DIV_WAIT
  } state_t;

endpackage

### src/iou_match_ram.sv
// Generic single-write, single-read RAM with registered read data.
module iou_match_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/iou_match_div.sv
// Restoring divider that forms floor(num * 65536 / den) one bit per cycle.
module iou_match_div (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic [iou_match_pkg::AREA_BITS-1:0]  num,
  input  logic [iou_match_pkg::UNION_BITS-1:0] den,
  output logic                                 done,
  output logic [iou_match_pkg::QUOT_BITS-1:0]  quot
);
  import iou_match_pkg::*;

  localparam int REM_BITS  = UNION_BITS + 1;
  localparam int STEP_BITS = $clog2(QUOT_BITS + 1);

  logic [REM_BITS-1:0]   rem;
  logic [UNION_BITS-1:0] dvs;
  logic [STEP_BITS-1:0]  steps;
  logic                  first;
  logic                  running;
  logic [REM_BITS-1:0]   cand;
  logic                  take;

  // The numerator never exceeds the denominator, so the first quotient bit
  // is a plain compare and every later bit follows a left shift.
  always_comb begin
    cand = first ? rem : {rem[REM_BITS-2:0], 1'b0};
    take = (cand >= REM_BITS'(dvs));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
      end else if (running && steps == STEP_BITS'(1)) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end
  end

  // Shift and subtract datapath.
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= REM_BITS'(num);
      dvs   <= den;
      steps <= STEP_BITS'(QUOT_BITS);
      first <= 1'b1;
      quot  <= '0;
    end else if (running) begin
      rem   <= take ? (cand - REM_BITS'(dvs)) : cand;
      quot  <= {quot[QUOT_BITS-2:0], take};
      steps <= steps - STEP_BITS'(1);
      first <= 1'b0;
    end
  end

endmodule

### src/max_iou_ground_truth_match_top.sv
// Top level of the max-IoU ground-truth matcher: control, table walk and results.
//
// A load, clear or unused request returns its result in the cycle after it is
// taken and leaves busy low. An evaluate request keeps busy high while the
// box table memory is walked entry by entry: the proposal area first,
// then for each loaded entry a memory read, overlap edges, area multiply,
// union, cross multiply and compare, then one final table check, the start of
// the bit-serial divider, seventeen divider steps, the divider's report and
// the posting of the result. If no entry gives a nonzero union, the divider
// is skipped and no match is posted. The result strobe done is high for one
// cycle and cannot be held off, so capture the result on that cycle.
module max_iou_ground_truth_match_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func,
  input  logic [11:0] box_left,
  input  logic [11:0] box_top,
  input  logic [11:0] box_right,
  input  logic [11:0] box_bottom,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  output logic        done,
  output logic [1:0]  status,
  output logic [3:0]  best_index,
  output logic [16:0] iou_value,
  output logic        covers_best,
  output logic        keep_flag
);
  import iou_match_pkg::*;

  state_t state, state_next;

  logic [THR_BITS-1:0]   keep_high;
  logic [THR_BITS-1:0]   keep_low;
  logic [CNT_BITS-1:0]   count;
  logic [CNT_BITS-1:0]   idx;
  box_t                  in_box;
  box_t                  prop;
  box_t                  g;
  box_t                  best_box;
  box_t                  rd_box;
  logic [AREA_BITS-1:0]  p_area;
  coord_t                ow, oh, gw, gh;
  logic [AREA_BITS-1:0]  inter, garea;
  logic [UNION_BITS-1:0] un;
  logic [PROD_BITS-1:0]  p1, p2;
  logic                  found;
  logic [IDX_BITS-1:0]   best_idx;
  logic [AREA_BITS-1:0]  best_i;
  logic [UNION_BITS-1:0] best_u;
  logic                  accept;
  logic                  wr_en;
  logic                  div_start;
  logic                  div_done;
  logic [QUOT_BITS-1:0]  div_q;
  logic                  p_valid, g_valid;
  coord_t                ml, mt, mr, mb;

  assign accept = start && !busy;
  assign in_box = '{l: COORD_BITS'(box_left), t: COORD_BITS'(box_top),
                    r: COORD_BITS'(box_right), b: COORD_BITS'(box_bottom)};
  assign wr_en  = accept && func == FUNC_LOAD && count < CNT_BITS'(TABLE_DEPTH);
  assign div_start = (state == S_DIV_START);

  iou_match_ram #(
    .WIDTH(BOX_BITS),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (count[IDX_BITS-1:0]),
    .wdata (in_box),
    .raddr (idx[IDX_BITS-1:0]),
    .rdata (rd_box)
  );

  iou_match_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (best_i),
    .den   (best_u),
    .done  (div_done),
    .quot  (div_q)
  );

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and busy.
  always_comb begin
    state_next = state;
    busy       = (state != S_IDLE);
    unique case (state)
      S_IDLE:      if (accept && func == FUNC_EVAL) state_next = S_PAREA;
      S_PAREA:     state_next = S_READ;
      S_READ: begin
        if (idx == count) begin
          state_next = found ? S_DIV_START : S_IDLE;
        end else begin
          state_next = S_DIM;
        end
      end
      S_DIM:       state_next = S_MUL;
      S_MUL:       state_next = S_UNI;
      S_UNI:       state_next = S_CMP;
      S_CMP:       state_next = S_UPD;
      S_UPD:       state_next = S_READ;
      S_DIV_START: state_next = S_DIV_WAIT;
      S_DIV_WAIT:  if (div_done) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // Overlap edges of the proposal and the entry just read.
  always_comb begin
    p_valid = (prop.r >= prop.l) && (prop.b >= prop.t);
    g_valid = (rd_box.r >= rd_box.l) && (rd_box.b >= rd_box.t);
    ml = (prop.l > rd_box.l) ? prop.l : rd_box.l;
    mt = (prop.t > rd_box.t) ? prop.t : rd_box.t;
    mr = (prop.r < rd_box.r) ? prop.r : rd_box.r;
    mb = (prop.b < rd_box.b) ? prop.b : rd_box.b;
  end

  // Configuration registers, table count and result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      keep_high <= THR_BITS'(32768);
      keep_low  <= THR_BITS'(19661);
      count     <= '0;
      done      <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_KEEP_HIGH) begin
          keep_high <= cfg_data;
        end else begin
          keep_low <= cfg_data;
        end
      end
      if (wr_en) begin
        count <= count + CNT_BITS'(1);
      end else if (accept && func == FUNC_CLEAR) begin
        count <= '0;
      end
      done <= (accept && func != FUNC_EVAL) ||
              (state == S_READ && idx == count && !found) ||
              (state == S_DIV_WAIT && div_done);
    end
  end

  // Walk datapath and result registers.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          prop        <= in_box;
          idx         <= '0;
          found       <= 1'b0;
          status      <= (func == FUNC_LOAD && !wr_en) ? STATUS_FULL : STATUS_OK;
          best_index  <= '0;
          iou_value   <= '0;
          covers_best <= 1'b0;
          keep_flag   <= 1'b0;
        end
      end
      S_PAREA: begin
        if ((prop.r >= prop.l) && (prop.b >= prop.t)) begin
          p_area <= AREA_BITS'(prop.r - prop.l) * AREA_BITS'(prop.b - prop.t);
        end else begin
          p_area <= '0;
        end
      end
      S_READ: begin
        if (idx == count && !found) begin
          status <= STATUS_NO_MATCH;
        end
      end
      S_DIM: begin
        g <= rd_box;
        if (p_valid && g_valid && mr > ml && mb > mt) begin
          ow <= mr - ml;
          oh <= mb - mt;
        end else begin
          ow <= '0;
          oh <= '0;
        end
        gw <= g_valid ? (rd_box.r - rd_box.l) : '0;
        gh <= g_valid ? (rd_box.b - rd_box.t) : '0;
      end
      S_MUL: begin
        inter <= AREA_BITS'(ow) * AREA_BITS'(oh);
        garea <= AREA_BITS'(gw) * AREA_BITS'(gh);
      end
      S_UNI: begin
        un <= UNION_BITS'(p_area) + UNION_BITS'(garea) - UNION_BITS'(inter);
      end
      S_CMP: begin
        p1 <= PROD_BITS'(inter) * PROD_BITS'(best_u);
        p2 <= PROD_BITS'(best_i) * PROD_BITS'(un);
      end
      S_UPD: begin
        // Lowest index wins ties: only a strictly better ratio replaces.
        if (un != '0 && (!found || p1 > p2)) begin
          found    <= 1'b1;
          best_idx <= idx[IDX_BITS-1:0];
          best_i   <= inter;
          best_u   <= un;
          best_box <= g;
        end
        idx <= idx + CNT_BITS'(1);
      end
      S_DIV_START: begin
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          status      <= STATUS_OK;
          best_index  <= 4'(best_idx);
          iou_value   <= div_q;
          covers_best <= (prop.l <= best_box.l) && (prop.t <= best_box.t) &&
                         (prop.r >= best_box.r) && (prop.b >= best_box.b);
          keep_flag   <= (div_q >= QUOT_BITS'(keep_high)) ||
                         (div_q <= QUOT_BITS'(keep_low));
        end
      end
      default: begin
      end
    endcase
  end

endmodule
